FILE: sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the history block. Bodies are empty
// when SYNTH is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/guh_pkg.sv
// ============================================================================
// Grouped undo/redo history package
// Shared widths, codes and payload types of the history block.
// ============================================================================
`default_nettype none

package guh_pkg;

    // Default number of history entries.
    localparam int DEFAULT_HISTORY_DEPTH = 256;

    // Fixed field widths.
    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 6;
    localparam int IDX_W    = 9;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 2;

    // Action codes on the command port.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UNDO   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REDO   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    // Classified operation handed from front to back.
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_UNDO,
        OP_REDO,
        OP_NONE
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ENTRY    = 2'd0,
        ST_NOTHING  = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Edit fields of one history entry.
    typedef struct packed {
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] column;
        logic               invalid;
        logic [FIELD_W-1:0] old_value;
        logic [FIELD_W-1:0] new_value;
        logic               old_fixed;
        logic               new_fixed;
    } t_edit;

    // Stored entry: edit fields plus the group start mark.
    typedef struct packed {
        t_edit edit;
        logic  start;
    } t_entry;

    // Command held in the queue.
    typedef struct packed {
        t_op    op;
        t_entry entry;
    } t_cmd;

    // Result payload.
    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
        t_edit            edit;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/guh_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module guh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: sv/guh_front.sv
// ============================================================================
// History front end
// Accepts commands, classifies the action code and queues the command for
// the back end.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module guh_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [guh_pkg::ACTION_W-1:0]   i_action,
    input  wire guh_pkg::t_entry                i_entry,
    output logic                                o_busy,
    output logic                                o_cmd_valid,
    output guh_pkg::t_cmd                       o_cmd,
    input  wire logic                           i_pop
);

    import guh_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW  = $clog2(Q_DEPTH + 1);

    t_cmd            r_q [Q_DEPTH];
    logic [QAW-1:0]  r_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            full;
    logic            push;
    t_op             op;
    t_cmd            cmd_in;

    // Classify the action code.
    always_comb begin
        unique case (i_action)
            ACT_INSERT: op = OP_INSERT;
            ACT_UNDO:   op = OP_UNDO;
            ACT_REDO:   op = OP_REDO;
            ACT_NONE:   op = OP_NONE;
        endcase
    end

    assign cmd_in.op    = op;
    assign cmd_in.entry = i_entry;

    assign full   = (r_count == CW'(Q_DEPTH));
    assign o_busy = full;
    assign push   = i_start && !full;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // The back end only takes a command that the queue holds.
    `ASSERT_CLK(a_pop_not_empty, i_clk, i_rst_n, i_pop |-> (r_count != '0), "pop from empty queue")

endmodule

`default_nettype wire

FILE: sv/guh_back.sv
// ============================================================================
// History back end
// Sequencer that carries out insert, undo and redo, walking the entry store
// one entry at a time to find group boundaries.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module guh_back #(
    parameter int HISTORY_DEPTH = guh_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cmd_valid,
    input  wire guh_pkg::t_cmd                    i_cmd,
    output logic                                  o_pop,
    output logic                                  o_wr_en,
    output logic [$clog2(HISTORY_DEPTH)-1:0]      o_wr_addr,
    output guh_pkg::t_entry                       o_wr_data,
    output logic [$clog2(HISTORY_DEPTH)-1:0]      o_rd_addr,
    input  wire guh_pkg::t_entry                  i_rd_data,
    output logic                                  o_strobe,
    output guh_pkg::t_result                      o_res
);

    import guh_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int PW = $clog2(HISTORY_DEPTH + 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_TEST,
        S_INS_CHECK,
        S_INS_END,
        S_UNDO_WAIT,
        S_UNDO_OUT,
        S_UNDO_TEST,
        S_UNDO_CHECK,
        S_RDO_TEST,
        S_RDO_CHECK
    } t_state;

    t_state             r_state;
    t_op                r_op;
    t_entry             r_entry;
    logic [PW-1:0]      r_pos;
    logic [PW-1:0]      r_cursor;
    logic [PW-1:0]      r_len;
    logic               r_strobe;
    t_result            r_res;

    logic [PW-1:0]       pos_m1;
    logic [PW-1:0]       pos_p1;
    logic [PW+IDX_W-1:0] pos_wide;
    logic [PW+IDX_W-1:0] pos_p1_wide;
    logic                at_full;

    // Position arithmetic and the store addresses it selects.
    assign pos_m1      = r_pos - 1'b1;
    assign pos_p1      = r_pos + 1'b1;
    assign pos_wide    = {{IDX_W{1'b0}}, r_pos};
    assign pos_p1_wide = {{IDX_W{1'b0}}, pos_p1};
    assign at_full     = (r_pos == PW'(HISTORY_DEPTH));

    assign o_rd_addr = (r_op == OP_INSERT) ? r_pos[AW-1:0] : pos_m1[AW-1:0];
    assign o_wr_en   = (r_state == S_INS_END) && !at_full;
    assign o_wr_addr = r_pos[AW-1:0];
    assign o_wr_data = r_entry;
    assign o_pop     = (r_state == S_IDLE) && i_cmd_valid;

    // Sequencer state, history pointers and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_NONE;
            r_cursor <= '0;
            r_len    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op    <= i_cmd.op;
                        r_entry <= i_cmd.entry;
                        unique case (i_cmd.op)
                            OP_INSERT: begin
                                r_pos   <= r_cursor;
                                r_state <= S_INS_TEST;
                            end
                            OP_UNDO: begin
                                if (r_cursor == '0) begin
                                    r_strobe         <= 1'b1;
                                    r_res.status     <= ST_NOTHING;
                                    r_res.index      <= '0;
                                    r_res.edit       <= '0;
                                end else begin
                                    r_pos   <= r_cursor;
                                    r_state <= S_UNDO_WAIT;
                                end
                            end
                            OP_REDO: begin
                                r_pos   <= r_cursor + 1'b1;
                                r_state <= S_RDO_TEST;
                            end
                            OP_NONE: begin
                                r_strobe     <= 1'b1;
                                r_res.status <= ST_NOTHING;
                                r_res.index  <= '0;
                                r_res.edit   <= '0;
                            end
                        endcase
                    end
                end
                // Insert: walk to the last entry of the cursor's group.
                S_INS_TEST: begin
                    r_state <= (r_pos < r_len) ? S_INS_CHECK : S_INS_END;
                end
                S_INS_CHECK: begin
                    if (i_rd_data.start) begin
                        r_state <= S_INS_END;
                    end else begin
                        r_pos   <= pos_p1;
                        r_state <= S_INS_TEST;
                    end
                end
                S_INS_END: begin
                    r_strobe    <= 1'b1;
                    r_res.edit  <= '0;
                    if (at_full) begin
                        r_res.status <= ST_FULL;
                        r_res.index  <= '0;
                    end else begin
                        r_res.status <= ST_INSERTED;
                        r_res.index  <= pos_p1_wide[IDX_W-1:0];
                        r_len        <= pos_p1;
                        if (r_entry.start) begin
                            r_cursor <= pos_p1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                // Undo: hand back the cursor's entry, then walk back.
                S_UNDO_WAIT: begin
                    r_state <= S_UNDO_OUT;
                end
                S_UNDO_OUT: begin
                    r_strobe     <= 1'b1;
                    r_res.status <= ST_ENTRY;
                    r_res.index  <= pos_wide[IDX_W-1:0];
                    r_res.edit   <= i_rd_data.edit;
                    r_pos        <= pos_m1;
                    r_state      <= S_UNDO_TEST;
                end
                S_UNDO_TEST: begin
                    if (r_pos == '0) begin
                        r_cursor <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_UNDO_CHECK;
                    end
                end
                S_UNDO_CHECK: begin
                    if (i_rd_data.start) begin
                        r_cursor <= r_pos;
                        r_state  <= S_IDLE;
                    end else begin
                        r_pos   <= pos_m1;
                        r_state <= S_UNDO_TEST;
                    end
                end
                // Redo: walk forward to the next group start.
                S_RDO_TEST: begin
                    if (r_pos > r_len) begin
                        r_strobe     <= 1'b1;
                        r_res.status <= ST_NOTHING;
                        r_res.index  <= '0;
                        r_res.edit   <= '0;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_RDO_CHECK;
                    end
                end
                S_RDO_CHECK: begin
                    if (i_rd_data.start) begin
                        r_cursor     <= r_pos;
                        r_strobe     <= 1'b1;
                        r_res.status <= ST_ENTRY;
                        r_res.index  <= pos_wide[IDX_W-1:0];
                        r_res.edit   <= i_rd_data.edit;
                        r_state      <= S_IDLE;
                    end else begin
                        r_pos   <= pos_p1;
                        r_state <= S_RDO_TEST;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // The cursor never passes the end of the history.
    `ASSERT_CLK(a_cursor_in_range, i_clk, i_rst_n, r_cursor <= r_len, "cursor beyond history length")
    // The history never grows past the store.
    `ASSERT_CLK(a_len_in_range, i_clk, i_rst_n, r_len <= PW'(HISTORY_DEPTH), "history length beyond depth")
    // Every store write is reported as an insert in the next cycle.
    `ASSERT_CLK(a_write_reported, i_clk, i_rst_n, o_wr_en |=> (r_strobe && (r_res.status == ST_INSERTED)), "write without insert result")
    // A returned entry always names a real position.
    `ASSERT_CLK(a_entry_has_pos, i_clk, i_rst_n, (r_strobe && (r_res.status == ST_ENTRY)) |-> ($past(r_pos) != '0), "entry returned at the edge")

endmodule

`default_nettype wire

FILE: sv/grouped_undo_redo_history.sv
// Sequence: undo or the unused code with nothing to do strobes straight from IDLE; insert walks
// INS_TEST and INS_CHECK, one store read per entry, and strobes from INS_END; undo strobes from
// UNDO_OUT after UNDO_WAIT, then walks back; redo walks RDO_TEST and RDO_CHECK to its strobe.
// Queue: a two-entry command queue takes new commands while the sequencer works, until it is full
// (busy high). The result strobe cannot be stalled.
// Reset: synchronous, active low; clears cursor, length, queue and sequencer, not the store.
// ============================================================================
// Grouped undo/redo history
// Top level: command front end, queue, sequencer back end and entry store.
// ============================================================================
`default_nettype none

module grouped_undo_redo_history #(
    parameter int HISTORY_DEPTH = guh_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [guh_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [guh_pkg::FIELD_W-1:0]   i_cell_row,
    input  wire logic [guh_pkg::FIELD_W-1:0]   i_cell_column,
    input  wire logic                          i_was_invalid,
    input  wire logic [guh_pkg::FIELD_W-1:0]   i_old_value,
    input  wire logic [guh_pkg::FIELD_W-1:0]   i_new_value,
    input  wire logic                          i_old_fixed,
    input  wire logic                          i_new_fixed,
    input  wire logic                          i_starts_group,
    output logic                               o_strobe,
    output logic [1:0]                         o_status,
    output logic [guh_pkg::IDX_W-1:0]          o_entry_index,
    output logic [guh_pkg::FIELD_W-1:0]        o_out_row,
    output logic [guh_pkg::FIELD_W-1:0]        o_out_column,
    output logic                               o_out_invalid,
    output logic [guh_pkg::FIELD_W-1:0]        o_out_old_value,
    output logic [guh_pkg::FIELD_W-1:0]        o_out_new_value,
    output logic                               o_out_old_fixed,
    output logic                               o_out_new_fixed
);

    import guh_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    t_entry          in_entry;
    logic            cmd_valid;
    t_cmd            cmd;
    logic            pop;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;
    logic [AW-1:0]   rd_addr;
    t_entry          rd_data;
    t_result         res;

    // Gather the payload ports into one entry.
    assign in_entry.edit.row       = i_cell_row;
    assign in_entry.edit.column    = i_cell_column;
    assign in_entry.edit.invalid   = i_was_invalid;
    assign in_entry.edit.old_value = i_old_value;
    assign in_entry.edit.new_value = i_new_value;
    assign in_entry.edit.old_fixed = i_old_fixed;
    assign in_entry.edit.new_fixed = i_new_fixed;
    assign in_entry.start          = i_starts_group;

    guh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_action    (i_action),
        .i_entry     (in_entry),
        .o_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    guh_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_strobe    (o_strobe),
        .o_res       (res)
    );

    guh_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (HISTORY_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Spread the result over the output ports.
    assign o_status        = res.status;
    assign o_entry_index   = res.index;
    assign o_out_row       = res.edit.row;
    assign o_out_column    = res.edit.column;
    assign o_out_invalid   = res.edit.invalid;
    assign o_out_old_value = res.edit.old_value;
    assign o_out_new_value = res.edit.new_value;
    assign o_out_old_fixed = res.edit.old_fixed;
    assign o_out_new_fixed = res.edit.new_fixed;

endmodule

`default_nettype wire
